[hw/rtl/gpo_pkg.sv]
// Shared types, codes and constants of the GPIO pin ownership controller.
package gpo_pkg;

    localparam int GPO_NUM_PINS   = 32;
    localparam int GPO_OWNER_BITS = 16;

    localparam logic [31:0] GPO_RESERVED_RESET = 32'h0439_3063;

    localparam logic [1:0] VAL_SET         = 2'd1;
    localparam logic [1:0] VAL_MODE_INPUT  = 2'd0;
    localparam logic [1:0] VAL_MODE_OUTPUT = 2'd1;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_REQUEST = 3'd2,
        OP_FREE    = 3'd3,
        OP_TOGGLE  = 3'd4,
        OP_MODE    = 3'd5,
        OP_RELEASE = 3'd6,
        OP_INVALID = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BADPIN = 3'd1,
        ST_DENIED = 3'd2,
        ST_BUSY   = 3'd3,
        ST_BADCMD = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    typedef struct packed {
        status_t     status;
        logic        level;
        logic        owner_we;
        logic        owner_set;
        logic [31:0] latch_next;
        logic [31:0] dir_next;
    } exec_res_t;

endpackage

[hw/rtl/gpo_owner_ram.sv]
// Owner table memory: one write port, one registered read port, per-entry valid bits.
module gpo_owner_ram
    import gpo_pkg::*;
#(
    parameter int DEPTH = GPO_NUM_PINS,
    parameter int WIDTH = GPO_OWNER_BITS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] owner_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= owner_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[hw/rtl/gpo_exec.sv]
// Operation evaluation: checks ownership and mask, computes status, level and next state.
module gpo_exec
    import gpo_pkg::*;
#(
    parameter int NUM_PINS   = GPO_NUM_PINS,
    parameter int OWNER_BITS = GPO_OWNER_BITS
)
(
    input  op_t                   op,
    input  logic [4:0]            pin,
    input  logic [OWNER_BITS-1:0] who,
    input  logic [1:0]            value,
    input  logic [31:0]           pads,
    input  logic [OWNER_BITS-1:0] owner_rd,
    input  logic [31:0]           mask,
    input  logic [31:0]           latch,
    input  logic [31:0]           dir,
    output exec_res_t             res
);

    logic        pin_ok;
    logic [31:0] pin_bit;
    logic        reserved;
    logic        pad;
    logic        who_nz;
    logic        match;
    logic        is_owner;

    always_comb
    begin
        pin_ok   = {1'b0, pin} < 6'(NUM_PINS);
        pin_bit  = 32'd1 << pin;
        reserved = mask[pin];
        pad      = pads[pin];
        who_nz   = who != '0;
        match    = who_nz && (owner_rd == who);
        is_owner = pin_ok && match;

        res.status     = ST_OK;
        res.level      = 1'b0;
        res.owner_we   = 1'b0;
        res.owner_set  = 1'b0;
        res.latch_next = latch;
        res.dir_next   = dir;

        case (op)
            OP_INVALID:
            begin
                res.status = ST_BADCMD;
            end
            OP_RELEASE:
            begin
                res.owner_we = match;
            end
            default:
            begin
                if (!pin_ok)
                begin
                    res.status = ST_BADPIN;
                end
                else if (op == OP_READ)
                begin
                    res.level = pad;
                end
                else if (op == OP_WRITE)
                begin
                    if (reserved || !is_owner)
                    begin
                        res.status = ST_DENIED;
                    end
                    else if (value == VAL_SET)
                    begin
                        res.latch_next = latch | pin_bit;
                    end
                    else
                    begin
                        res.latch_next = latch & ~pin_bit;
                    end
                end
                else if (reserved)
                begin
                    res.status = ST_BADPIN;
                end
                else
                begin
                    case (op)
                        OP_REQUEST:
                        begin
                            if (!who_nz)
                            begin
                                res.status = ST_DENIED;
                            end
                            else if (owner_rd != '0)
                            begin
                                res.status = ST_BUSY;
                            end
                            else
                            begin
                                res.owner_we  = 1'b1;
                                res.owner_set = 1'b1;
                            end
                        end
                        OP_FREE:
                        begin
                            if (is_owner)
                            begin
                                res.owner_we = 1'b1;
                            end
                            else
                            begin
                                res.status = ST_BADPIN;
                            end
                        end
                        OP_TOGGLE:
                        begin
                            if (!is_owner)
                            begin
                                res.status = ST_DENIED;
                            end
                            else
                            begin
                                res.level      = ~pad;
                                res.latch_next = pad ? (latch & ~pin_bit) : (latch | pin_bit);
                            end
                        end
                        default:
                        begin
                            if (!is_owner)
                            begin
                                res.status = ST_DENIED;
                            end
                            else if (value == VAL_MODE_INPUT)
                            begin
                                res.dir_next = dir & ~pin_bit;
                            end
                            else if (value == VAL_MODE_OUTPUT)
                            begin
                                res.dir_next = dir | pin_bit;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

[hw/rtl/gpio_pin_ownership_controller_top.sv]
// Top level: request capture, sequencer, owner table, drive and direction registers.
// Sequence: single-pin ops pass S_EXEC, release-owner passes S_SCAN; done is registered from
// the last evaluation. busy covers both states, so a new transaction waits for S_IDLE. The scan
// reads and writes back one owner table entry per cycle on its single port pair.
// Reset: every pin free (owner table valid bits cleared), latch and directions zero,
// reserved mask 0x04393063; no clearing pass. The receiver cannot stall: done lasts one cycle.
module gpio_pin_ownership_controller_top
    import gpo_pkg::*;
#(
    parameter int NUM_PINS   = GPO_NUM_PINS,
    parameter int OWNER_BITS = GPO_OWNER_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [4:0]  pin_number,
    input  logic [15:0] owner_id,
    input  logic [1:0]  value,
    input  logic [31:0] pad_levels,
    output logic        done,
    output logic [2:0]  status,
    output logic        level,
    output logic [31:0] drive_levels,
    output logic [31:0] output_enables,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int PIN_IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    state_t state_reg;
    state_t state_next;

    op_t                   op_reg;
    logic [4:0]            pin_reg;
    logic [OWNER_BITS-1:0] who_reg;
    logic [1:0]            value_reg;
    logic [31:0]           pads_reg;

    logic [PIN_IDX_W-1:0]  scan_idx_reg;
    logic [PIN_IDX_W-1:0]  scan_idx_next;
    logic                  scan_last;

    logic [31:0]           mask_reg;
    logic [31:0]           latch_reg;
    logic [31:0]           dir_reg;
    logic                  done_reg;
    status_t               status_reg;
    logic                  level_reg;

    logic                  accept;
    logic                  pin_in_range;
    logic                  rd_en;
    logic [PIN_IDX_W-1:0]  rd_addr;
    logic [OWNER_BITS-1:0] owner_rd;
    logic                  wr_en;
    logic [PIN_IDX_W-1:0]  wr_addr;
    logic [OWNER_BITS-1:0] wr_data;
    logic                  load_result;
    exec_res_t             ex;

    assign busy         = state_reg != S_IDLE;
    assign accept       = start && !busy;
    assign pin_in_range = {1'b0, pin_number} < 6'(NUM_PINS);
    assign scan_last    = scan_idx_reg == PIN_IDX_W'(NUM_PINS - 1);
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (op_t'(operation) == OP_RELEASE) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en         = 1'b0;
        rd_addr       = pin_number[PIN_IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = pin_reg[PIN_IDX_W-1:0];
        load_result   = 1'b0;
        scan_idx_next = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (op_t'(operation) == OP_RELEASE)
                begin
                    rd_en   = start;
                    rd_addr = '0;
                end
                else
                begin
                    rd_en = start && pin_in_range;
                end
            end
            S_EXEC:
            begin
                wr_en       = ex.owner_we;
                load_result = 1'b1;
            end
            S_SCAN:
            begin
                rd_en         = !scan_last;
                rd_addr       = PIN_IDX_W'(scan_idx_reg + 1'b1);
                wr_en         = ex.owner_we;
                wr_addr       = scan_idx_reg;
                load_result   = scan_last;
                scan_idx_next = PIN_IDX_W'(scan_idx_reg + 1'b1);
            end
            default:
            begin
                load_result = 1'b0;
            end
        endcase
    end

    assign wr_data = ex.owner_set ? who_reg : '0;

    gpo_owner_ram #(
        .DEPTH (NUM_PINS),
        .WIDTH (OWNER_BITS)
    ) u_owner_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (owner_rd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gpo_exec #(
        .NUM_PINS   (NUM_PINS),
        .OWNER_BITS (OWNER_BITS)
    ) u_exec (
        .op       (op_reg),
        .pin      (pin_reg),
        .who      (who_reg),
        .value    (value_reg),
        .pads     (pads_reg),
        .owner_rd (owner_rd),
        .mask     (mask_reg),
        .latch    (latch_reg),
        .dir      (dir_reg),
        .res      (ex)
    );

    // Hold the transaction payload for the read-modify-write.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(operation);
            pin_reg   <= pin_number;
            who_reg   <= OWNER_BITS'(owner_id);
            value_reg <= value;
            pads_reg  <= pad_levels;
        end
        if (load_result)
        begin
            status_reg <= ex.status;
            level_reg  <= ex.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            mask_reg     <= GPO_RESERVED_RESET;
            latch_reg    <= '0;
            dir_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            done_reg     <= load_result;
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
            if (load_result)
            begin
                latch_reg <= ex.latch_next;
                dir_reg   <= ex.dir_next;
            end
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign level          = level_reg;
    assign drive_levels   = latch_reg;
    assign output_enables = dir_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_short_op_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op_t'(operation) != OP_RELEASE) |=> busy ##1 (done && !busy))
        else $error("single-pin transaction did not complete in two cycles");

    a_level_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!level || status == ST_OK))
        else $error("level set on a failed transaction");

endmodule
